// ===== design/bfr_pkg.sv =====
package bfr_pkg;

    localparam int NumFrames = 16;
    localparam int PageBits  = 24;
    localparam int FrameBits = $clog2(NumFrames);
    localparam int CountBits = $clog2(NumFrames + 1);

    localparam logic [2:0] FUNC_PIN   = 3'd0;
    localparam logic [2:0] FUNC_UNPIN = 3'd1;
    localparam logic [2:0] FUNC_DIRTY = 3'd2;
    localparam logic [2:0] FUNC_FORCE = 3'd3;
    localparam logic [2:0] FUNC_FLUSH = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_VICT  = 2'd1;
    localparam logic [1:0] ST_NOT_RES  = 2'd2;

    localparam logic CFG_MODE   = 1'b0;
    localparam logic CFG_FRAMES = 1'b1;

    typedef struct packed {
        logic [2:0]          func;
        logic [PageBits-1:0] page_number;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  frame_index;
        logic        hit;
        logic        load_needed;
        logic        writeback_needed;
        logic [23:0] writeback_page;
        logic [7:0]  pin_count;
        logic [31:0] read_io_count;
        logic [31:0] write_io_count;
        logic        last;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic start;      // load request, reset scan
        logic scan;       // examine frame at scan index, advance
        logic apply;      // commit the operation for the current request
        logic flush_one;  // write back frame at scan index
        logic emit_none;  // emit a single result with no frame
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       scan_done;
        logic       cur_dirty;  // frame at scan index is valid and dirty
        logic [2:0] func;
    } t_sts;

endpackage

// ===== design/bfr_if.sv =====
interface bfr_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/bfr_ctrl.sv =====
module bfr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_busy,
    input  bfr_pkg::t_sts  i_sts,
    output bfr_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_FLUSH, S_WAIT} t_state;

    t_state r_state;
    logic   r_flushed;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:  o_cmd.start = i_in_valid;
            // flush skips the match scan and walks the frames from index zero
            S_SCAN:  o_cmd.scan  = (i_sts.func != bfr_pkg::FUNC_FLUSH);
            S_APPLY: o_cmd.apply = !i_out_busy;
            S_FLUSH: begin
                if (!i_out_busy) begin
                    if (i_sts.scan_done) o_cmd.emit_none = !r_flushed;
                    else if (i_sts.cur_dirty) o_cmd.flush_one = 1'b1;
                    else o_cmd.scan = 1'b1;
                end
            end
            S_WAIT:  o_cmd = '0;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_flushed <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_state   <= S_SCAN;
                    r_flushed <= 1'b0;
                end
                S_SCAN: begin
                    if (i_sts.func == bfr_pkg::FUNC_FLUSH) r_state <= S_FLUSH;
                    else if (i_sts.scan_done) r_state <= S_APPLY;
                end
                S_APPLY: if (!i_out_busy) r_state <= S_WAIT;
                S_FLUSH: begin
                    if (!i_out_busy) begin
                        if (i_sts.scan_done) r_state <= S_WAIT;
                        else if (i_sts.cur_dirty) r_flushed <= 1'b1;
                    end
                end
                S_WAIT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== design/bfr_datapath.sv =====
module bfr_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bfr_pkg::t_req  i_req,
    input  logic           i_cfg_we,
    input  logic [0:0]     i_cfg_idx,
    input  logic [4:0]     i_cfg_data,
    input  bfr_pkg::t_cmd  i_cmd,
    output bfr_pkg::t_sts  o_sts,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output bfr_pkg::t_rsp  o_out
);

    localparam int NF = bfr_pkg::NumFrames;
    localparam int FB = bfr_pkg::FrameBits;
    localparam int CB = bfr_pkg::CountBits;
    localparam int PB = bfr_pkg::PageBits;

    logic [PB-1:0] r_page  [NF];
    logic [NF-1:0] r_valid;
    logic [NF-1:0] r_dirty;
    logic [7:0]    r_pins  [NF];
    logic [31:0]   r_stamp [NF];
    logic [31:0]   r_stamp_ctr, r_reads, r_writes;
    logic          r_mode;
    logic [4:0]    r_frames;

    bfr_pkg::t_req r_req;
    logic [CB-1:0] r_idx;
    logic          r_hit_f, r_free_f, r_vic_f;
    logic [FB-1:0] r_hit, r_free, r_vic;
    logic [31:0]   r_best;
    logic          r_out_valid;
    bfr_pkg::t_rsp r_out;

    logic [CB-1:0] n_active;
    logic [FB-1:0] cur;
    logic [31:0]   age;
    logic [FB-1:0] tgt;
    logic          busy;
    logic          more_dirty;

    always_comb begin
        if (r_frames == 5'd0) n_active = CB'(1);
        else if (32'(r_frames) > NF) n_active = CB'(NF);
        else n_active = CB'(r_frames);
    end

    assign cur  = r_idx[FB-1:0];
    assign age  = r_stamp_ctr - r_stamp[cur];
    assign busy = r_out_valid && !i_out_ready;

    // mark the final flush beat: no dirty frame remains past the current one
    always_comb begin
        more_dirty = 1'b0;
        for (int j = 0; j < NF; j++) begin
            if (j > int'(cur) && j < int'(n_active) && r_valid[j] && r_dirty[j])
                more_dirty = 1'b1;
        end
    end

    assign o_sts.scan_done = (r_idx >= n_active);
    assign o_sts.cur_dirty = r_valid[cur] && r_dirty[cur];
    assign o_sts.func      = r_req.func;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

    always_comb begin
        tgt = r_free_f ? r_free : r_vic;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_dirty     <= '0;
            for (int i = 0; i < NF; i++) begin
                r_pins[i]  <= '0;
                r_stamp[i] <= '0;
            end
            r_stamp_ctr <= '0;
            r_reads     <= '0;
            r_writes    <= '0;
            r_mode      <= 1'b0;
            r_frames    <= 5'd16;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == bfr_pkg::CFG_MODE) r_mode <= i_cfg_data[0];
                else r_frames <= i_cfg_data;
            end
            if (i_cmd.start) begin
                r_req    <= i_req;
                r_idx    <= '0;
                r_hit_f  <= 1'b0;
                r_free_f <= 1'b0;
                r_vic_f  <= 1'b0;
                r_best   <= '0;
            end
            if (i_cmd.scan && !o_sts.scan_done) begin
                r_idx <= r_idx + CB'(1);
                if (r_req.func != bfr_pkg::FUNC_FLUSH) begin
                    if (r_valid[cur] && r_page[cur] == r_req.page_number && !r_hit_f) begin
                        r_hit_f <= 1'b1;
                        r_hit   <= cur;
                    end
                    if (!r_valid[cur] && !r_free_f) begin
                        r_free_f <= 1'b1;
                        r_free   <= cur;
                    end
                    if (r_pins[cur] == 8'd0 && (!r_vic_f || age > r_best)) begin
                        r_vic_f <= 1'b1;
                        r_vic   <= cur;
                        r_best  <= age;
                    end
                end
            end
            if (i_cmd.flush_one) begin
                r_idx        <= r_idx + CB'(1);
                r_dirty[cur] <= 1'b0;
                r_writes     <= r_writes + 32'd1;
                r_out_valid  <= 1'b1;
                r_out        <= '{status: bfr_pkg::ST_OK, frame_index: 4'(cur), hit: 1'b0,
                    load_needed: 1'b0, writeback_needed: 1'b1,
                    writeback_page: 24'(r_page[cur]), pin_count: r_pins[cur],
                    read_io_count: r_reads, write_io_count: r_writes + 32'd1,
                    last: !more_dirty};
            end
            if (i_cmd.emit_none) begin
                r_out_valid <= 1'b1;
                r_out       <= '0;
                r_out.read_io_count  <= r_reads;
                r_out.write_io_count <= r_writes;
                r_out.last  <= 1'b1;
            end
            if (i_cmd.apply) begin
                r_out_valid <= 1'b1;
                r_out       <= '0;
                r_out.read_io_count  <= r_reads;
                r_out.write_io_count <= r_writes;
                r_out.last  <= 1'b1;
                case (r_req.func)
                    bfr_pkg::FUNC_PIN: begin
                        if (r_hit_f) begin
                            r_out.hit         <= 1'b1;
                            r_out.frame_index <= 4'(r_hit);
                            r_out.pin_count   <= (r_pins[r_hit] == 8'hFF) ? 8'hFF
                                                 : r_pins[r_hit] + 8'd1;
                            if (r_pins[r_hit] != 8'hFF) r_pins[r_hit] <= r_pins[r_hit] + 8'd1;
                            if (r_mode) begin
                                r_stamp[r_hit] <= r_stamp_ctr;
                                r_stamp_ctr    <= r_stamp_ctr + 32'd1;
                            end
                        end else if (!r_free_f && !r_vic_f) begin
                            r_out.status <= bfr_pkg::ST_NO_VICT;
                        end else begin
                            if (!r_free_f && r_dirty[tgt]) begin
                                r_out.writeback_needed <= 1'b1;
                                r_out.writeback_page   <= 24'(r_page[tgt]);
                                r_writes               <= r_writes + 32'd1;
                                r_out.write_io_count   <= r_writes + 32'd1;
                            end
                            r_page[tgt]  <= r_req.page_number;
                            r_valid[tgt] <= 1'b1;
                            r_dirty[tgt] <= 1'b0;
                            r_pins[tgt]  <= 8'd1;
                            r_stamp[tgt] <= r_stamp_ctr;
                            r_stamp_ctr  <= r_stamp_ctr + 32'd1;
                            r_reads      <= r_reads + 32'd1;
                            r_out.read_io_count <= r_reads + 32'd1;
                            r_out.frame_index   <= 4'(tgt);
                            r_out.load_needed   <= 1'b1;
                            r_out.pin_count     <= 8'd1;
                        end
                    end
                    bfr_pkg::FUNC_UNPIN, bfr_pkg::FUNC_DIRTY, bfr_pkg::FUNC_FORCE: begin
                        if (!r_hit_f) begin
                            r_out.status <= bfr_pkg::ST_NOT_RES;
                        end else begin
                            r_out.frame_index <= 4'(r_hit);
                            r_out.pin_count   <= r_pins[r_hit];
                            if (r_req.func == bfr_pkg::FUNC_UNPIN) begin
                                if (r_pins[r_hit] != 8'd0) begin
                                    r_pins[r_hit]   <= r_pins[r_hit] - 8'd1;
                                    r_out.pin_count <= r_pins[r_hit] - 8'd1;
                                end
                            end else if (r_req.func == bfr_pkg::FUNC_DIRTY) begin
                                r_dirty[r_hit] <= 1'b1;
                            end else if (r_dirty[r_hit]) begin
                                r_dirty[r_hit]         <= 1'b0;
                                r_writes               <= r_writes + 32'd1;
                                r_out.write_io_count   <= r_writes + 32'd1;
                                r_out.writeback_needed <= 1'b1;
                                r_out.writeback_page   <= 24'(r_page[r_hit]);
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== design/buffer_frame_replacement.sv =====
// Frame table of a page buffer pool. A request (pin, unpin, mark dirty,
// force page) is taken only while the controller is idle, so no new request
// is accepted before the last one is through: the table scan walks the
// active frames, one per cycle, where active is frames_in_use clamped to
// 1..16; then the scan is closed, the result is committed and posted, and a
// settle step follows. Flush all skips the match scan and walks the active
// frames one per cycle while the output is not stalled, posting one beat per
// dirty frame with last = 1 on the final one, or a single beat when nothing
// is dirty. Results sit in an output register; a stalled output holds the
// commit and the flush walk.
module buffer_frame_replacement (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfr_if.sink         in_ch,
    bfr_if.source       out_ch,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data
);

    bfr_pkg::t_cmd cmd;
    bfr_pkg::t_sts sts;
    bfr_pkg::t_rsp rsp;
    logic          out_valid;

    bfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_out_busy (out_valid && !out_ch.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bfr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (in_ch.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (out_valid),
        .i_out_ready (out_ch.ready),
        .o_out       (rsp)
    );

    assign out_ch.valid = out_valid;
    assign out_ch.data  = rsp;

endmodule
